### rtl/rpfa_pkg.sv
package rpfa_pkg;

  // Fixed field widths
  localparam int MODE_W     = 3;
  localparam int ADDR_W     = 27;
  localparam int STATUS_W   = 3;
  localparam int VALUE_W    = 16;
  localparam int CFG_W      = 15;
  localparam int PAGE_SHIFT = 12;
  localparam int IDX_W      = ADDR_W - PAGE_SHIFT;

  // Free page counter saturates at its full width
  localparam logic [VALUE_W-1:0] FC_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT   = 3'd0,
    MODE_ALLOC  = 3'd1,
    MODE_FREE   = 3'd2,
    MODE_INCREF = 3'd3,
    MODE_DECREF = 3'd4,
    MODE_GETREF = 3'd5,
    MODE_COUNT  = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_FREE   = 3'd1,
    STAT_BAD_ADDR  = 3'd2,
    STAT_UNDERFLOW = 3'd3,
    STAT_OVERFLOW  = 3'd4
  } status_t;

  // Outcome of a count update, handed from the count unit to the sequencer
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value;
    logic                 released;
    logic                 cnt_we;
  } cnt_res_t;

endpackage

### rtl/rpfa_in_if.sv
interface rpfa_in_if;
  import rpfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, output mode, output page_address, input ready);
  modport sink   (input valid, input mode, input page_address, output ready);
endinterface

### rtl/rpfa_out_if.sv
interface rpfa_out_if;
  import rpfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_address;
  logic [VALUE_W-1:0]  value;
  logic                page_released;

  modport source (output valid, output status, output result_address, output value,
                  output page_released, input ready);
  modport sink   (input valid, input status, input result_address, input value,
                  input page_released, output ready);
endinterface

### rtl/rpfa_ram.sv
module rpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/rpfa_addr_chk.sv
module rpfa_addr_chk #(
  parameter int NUM_PAGES = 32768,
  parameter int PAGE_W    = 15
) (
  input  logic [rpfa_pkg::ADDR_W-1:0] page_address,
  input  logic [rpfa_pkg::CFG_W-1:0]  first_page,
  output logic [PAGE_W-1:0]           page,
  output logic                        bad
);
  import rpfa_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [31:0]      idx32;

  // Frame index from the byte offset
  assign idx   = page_address[ADDR_W-1:PAGE_SHIFT];
  assign idx32 = 32'(idx);
  assign page  = idx32[PAGE_W-1:0];

  // Misaligned, beyond the pool, or inside the kernel image
  assign bad = (|page_address[PAGE_SHIFT-1:0]) ||
               (idx32 >= 32'(NUM_PAGES)) ||
               (idx32 < 32'(first_page));

endmodule

### rtl/rpfa_cnt_upd.sv
module rpfa_cnt_upd #(
  parameter int COUNT_BITS = 16
) (
  input  logic [rpfa_pkg::MODE_W-1:0] mode,
  input  logic                        bad,
  input  logic [COUNT_BITS-1:0]       cnt,
  output logic [COUNT_BITS-1:0]       new_cnt,
  output rpfa_pkg::cnt_res_t          res
);
  import rpfa_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [31:0] new32;
  logic [31:0] cur32;

  assign new32 = 32'(new_cnt);
  assign cur32 = 32'(cnt);

  // Saturating count update for free, incref, decref and getref
  always_comb begin
    new_cnt = cnt;
    res     = '0;
    case (mode)
      MODE_FREE, MODE_DECREF: begin
        if (bad) begin
          res.status = STAT_BAD_ADDR;
        end else if (cnt == '0) begin
          res.status = STAT_UNDERFLOW;
        end else begin
          new_cnt      = cnt - COUNT_BITS'(1);
          res.cnt_we   = 1'b1;
          res.value    = new32[VALUE_W-1:0];
          res.released = (mode == MODE_FREE) && (new_cnt == '0);
        end
      end
      MODE_INCREF: begin
        if (bad) begin
          res.status = STAT_BAD_ADDR;
        end else if (cnt == CNT_MAX) begin
          res.status = STAT_OVERFLOW;
          res.value  = cur32[VALUE_W-1:0];
        end else begin
          new_cnt    = cnt + COUNT_BITS'(1);
          res.cnt_we = 1'b1;
          res.value  = new32[VALUE_W-1:0];
        end
      end
      MODE_GETREF: begin
        if (bad) begin
          res.status = STAT_BAD_ADDR;
        end else begin
          res.value = cur32[VALUE_W-1:0];
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

### rtl/refcounted_page_frame_allocator_core.sv
// Page frame allocator with a LIFO free list and per-frame reference counts.
// Input channel in_chan carries mode and page_address; each transfer gives
// exactly one transfer on out_chan (status, result_address, value,
// page_released). cfg_we/cfg_wdata set the first managed frame; write it
// only while no operation is in flight.
// Alloc, free, incref, decref, getref and count-free each read the count and
// link memories through their registered read port, then update and write
// back. Init sweeps every frame once, clearing its count and linking it onto
// the list if it is at or above the first managed frame, then replies.
// The result sits in an output register: one more operation is accepted while
// it waits, and that operation then holds in its update cycle until the
// register is taken. A stalled receiver thus holds the block after one item.
// After reset the count memory is cleared, one frame a cycle; in_chan.ready
// stays low meanwhile. Cfg writes are taken always.
// Reset leaves the free list empty, head 0 and the free counter 0.
module refcounted_page_frame_allocator_core #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rpfa_pkg::CFG_W-1:0] cfg_wdata,
  rpfa_in_if.sink                    in_chan,
  rpfa_out_if.source                 out_chan
);
  import rpfa_pkg::*;

  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_REPLY
  } state_t;

  state_t              state_r, state_nxt;
  logic [PAGE_W-1:0]   sweep_r, sweep_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic                bad_r, bad_nxt;
  logic [PAGE_W-1:0]   head_r, head_nxt;
  logic                empty_r, empty_nxt;
  logic [VALUE_W-1:0]  fc_r, fc_nxt;
  logic [CFG_W-1:0]    first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_rel_r, out_rel_nxt;

  logic                in_xfer;
  logic                out_free;
  logic [PAGE_W-1:0]   in_page;
  logic                in_bad;
  logic [PAGE_W-1:0]   cnt_raddr;
  logic                cnt_we;
  logic [PAGE_W-1:0]   cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic                link_we;
  logic [PAGE_W-1:0]   link_waddr;
  logic [PAGE_W-1:0]   link_wdata;
  logic [PAGE_W-1:0]   link_rd;
  logic [COUNT_BITS-1:0] new_cnt;
  cnt_res_t            upd;
  logic [31:0]         head32;
  logic [VALUE_W-1:0]  fc_dec;
  logic                in_range;

  // Handshake
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.result_address = out_addr_r;
  assign out_chan.value          = out_value_r;
  assign out_chan.page_released  = out_rel_r;

  // Address decode of the incoming item
  rpfa_addr_chk #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_W    (PAGE_W)
  ) u_addr_chk (
    .page_address (in_chan.page_address),
    .first_page   (first_r),
    .page         (in_page),
    .bad          (in_bad)
  );

  // Count read follows the input while idle, then holds on the latched page
  assign cnt_raddr = (state_r == ST_IDLE) ? in_page : page_r;

  rpfa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  // Link memory is always read at the current head
  rpfa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (head_r),
    .rdata (link_rd)
  );

  rpfa_cnt_upd #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt_upd (
    .mode    (mode_r),
    .bad     (bad_r),
    .cnt     (cnt_rd),
    .new_cnt (new_cnt),
    .res     (upd)
  );

  assign head32   = 32'(head_r);
  assign fc_dec   = (fc_r != '0) ? (fc_r - VALUE_W'(1)) : fc_r;
  assign in_range = (32'(sweep_r) >= 32'(first_r));

  // Sequencer next state and memory controls
  always_comb begin
    state_nxt      = state_r;
    sweep_nxt      = sweep_r;
    mode_nxt       = mode_r;
    page_nxt       = page_r;
    bad_nxt        = bad_r;
    head_nxt       = head_r;
    empty_nxt      = empty_r;
    fc_nxt         = fc_r;
    first_nxt      = cfg_we ? cfg_wdata : first_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_value_nxt  = out_value_r;
    out_rel_nxt    = out_rel_r;
    cnt_we         = 1'b0;
    cnt_waddr      = page_r;
    cnt_wdata      = new_cnt;
    link_we        = 1'b0;
    link_waddr     = page_r;
    link_wdata     = head_r;

    case (state_r)
      ST_CLEAR, ST_SWEEP: begin
        // One frame a cycle: clear its count, and on init push it if it is managed
        cnt_we    = 1'b1;
        cnt_waddr = sweep_r;
        cnt_wdata = '0;
        if (state_r == ST_SWEEP && in_range) begin
          link_we    = 1'b1;
          link_waddr = sweep_r;
          head_nxt   = sweep_r;
          empty_nxt  = 1'b0;
          fc_nxt     = (fc_r != FC_MAX) ? (fc_r + VALUE_W'(1)) : fc_r;
        end
        sweep_nxt = sweep_r + PAGE_W'(1);
        if (sweep_r == LAST_PAGE) begin
          sweep_nxt = '0;
          state_nxt = (state_r == ST_SWEEP) ? ST_REPLY : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt = in_chan.mode;
          page_nxt = in_page;
          bad_nxt  = in_bad;
          if (in_chan.mode == MODE_INIT) begin
            head_nxt  = '0;
            empty_nxt = 1'b1;
            fc_nxt    = '0;
            sweep_nxt = '0;
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_addr_nxt   = '0;
          out_value_nxt  = '0;
          out_rel_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
          case (mode_r)
            MODE_ALLOC: begin
              if (empty_r) begin
                out_status_nxt = STAT_NO_FREE;
              end else begin
                head_nxt      = link_rd;
                fc_nxt        = fc_dec;
                empty_nxt     = (fc_dec == '0);
                cnt_we        = 1'b1;
                cnt_waddr     = head_r;
                cnt_wdata     = COUNT_BITS'(1);
                out_addr_nxt  = {head32[IDX_W-1:0], {PAGE_SHIFT{1'b0}}};
                out_value_nxt = VALUE_W'(1);
              end
            end
            MODE_COUNT: begin
              out_value_nxt = fc_r;
            end
            MODE_FREE, MODE_INCREF, MODE_DECREF, MODE_GETREF: begin
              out_status_nxt = upd.status;
              out_value_nxt  = upd.value;
              out_rel_nxt    = upd.released;
              cnt_we         = upd.cnt_we;
              if (upd.released) begin
                link_we   = 1'b1;
                head_nxt  = page_r;
                empty_nxt = 1'b0;
                fc_nxt    = (fc_r != FC_MAX) ? (fc_r + VALUE_W'(1)) : fc_r;
              end
            end
            default: begin
              out_status_nxt = STAT_OK;
            end
          endcase
        end
      end
      ST_REPLY: begin
        // Init result: number of frames now on the list
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_addr_nxt   = '0;
          out_value_nxt  = fc_r;
          out_rel_nxt    = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sweep_r     <= '0;
      head_r      <= '0;
      empty_r     <= 1'b1;
      fc_r        <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      head_r      <= head_nxt;
      empty_r     <= empty_nxt;
      fc_r        <= fc_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    page_r       <= page_nxt;
    bad_r        <= bad_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_value_r  <= out_value_nxt;
    out_rel_r    <= out_rel_nxt;
  end

  // Free list is empty exactly when the free counter is zero
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r == (fc_r == '0))
    else $error("free list flag and free counter disagree");

  // An accepted item goes to its update step or to the init sweep
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_EXEC) || (state_r == ST_SWEEP))
    else $error("accepted item not dispatched");

  // A released frame comes only with an ok status and a zero count
  a_release_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rel_r) |-> (out_status_r == STAT_OK) && (out_value_r == '0))
    else $error("release reported with nonzero count or error");

endmodule

### tb/rpfa_frame_checker.sv
// Watches both channels of the frame allocator, keeps a shadow copy of the
// free list and the per-frame reference counts, and compares every result
// transfer against the oldest predicted reply.
module rpfa_frame_checker #(
  parameter int NUM_PAGES  = 32768,
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rpfa_pkg::CFG_W-1:0] cfg_wdata,
  rpfa_in_if                         in_mon,
  rpfa_out_if                        out_mon,
  output int unsigned                mismatches,
  output int unsigned                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rpfa_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   result_address;
    logic [VALUE_W-1:0]  value;
    logic                page_released;
  } frame_reply_t;

  // Shadow allocator state
  logic [COUNT_BITS-1:0] frame_refs [NUM_PAGES];
  logic [IDX_W-1:0]      frame_link [NUM_PAGES];
  logic [IDX_W-1:0]      head_frame;
  logic                  list_is_empty;
  logic [VALUE_W-1:0]    free_frames;
  logic [CFG_W-1:0]      base_frame;

  frame_reply_t replies_due [$];
  int unsigned  bad_fields = 0;

  assign mismatches = bad_fields;

  function automatic void push_frame(input logic [IDX_W-1:0] f);
    frame_link[f] = head_frame;
    head_frame    = f;
    list_is_empty = 1'b0;
    if (free_frames != FC_MAX) free_frames++;
  endfunction

  // Aligned, inside the pool and not below the first managed frame
  function automatic bit frame_ok(input logic [ADDR_W-1:0] a, output logic [IDX_W-1:0] f);
    f = a[ADDR_W-1:PAGE_SHIFT];
    return (a[PAGE_SHIFT-1:0] == '0) && (int'(f) < NUM_PAGES) && (f >= base_frame);
  endfunction

  function automatic frame_reply_t compute_frame_reply(input logic [MODE_W-1:0] m,
                                                       input logic [ADDR_W-1:0] a);
    frame_reply_t     r;
    logic [IDX_W-1:0] f;
    int               p;
    r = '0;
    case (m)
      MODE_INIT: begin
        foreach (frame_refs[i]) frame_refs[i] = '0;
        head_frame    = '0;
        list_is_empty = 1'b1;
        free_frames   = '0;
        for (p = int'(base_frame); p < NUM_PAGES; p++) push_frame(p[IDX_W-1:0]);
        r.value = free_frames;
      end
      MODE_ALLOC: begin
        if (list_is_empty) begin
          r.status = STAT_NO_FREE;
        end else begin
          f          = head_frame;
          head_frame = frame_link[f];
          if (free_frames != 0) free_frames--;
          if (free_frames == 0) list_is_empty = 1'b1;
          frame_refs[f]    = 1;
          r.result_address = {f, {PAGE_SHIFT{1'b0}}};
          r.value          = 1;
        end
      end
      MODE_FREE, MODE_DECREF: begin
        if (!frame_ok(a, f)) begin
          r.status = STAT_BAD_ADDR;
        end else if (frame_refs[f] == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          frame_refs[f]--;
          r.value = VALUE_W'(frame_refs[f]);
          // decref to zero leaves the frame off the list
          if (m == MODE_FREE && frame_refs[f] == 0) begin
            push_frame(f);
            r.page_released = 1'b1;
          end
        end
      end
      MODE_INCREF: begin
        if (!frame_ok(a, f)) begin
          r.status = STAT_BAD_ADDR;
        end else if (frame_refs[f] == COUNT_MAX) begin
          r.status = STAT_OVERFLOW;
          r.value  = VALUE_W'(frame_refs[f]);
        end else begin
          frame_refs[f]++;
          r.value = VALUE_W'(frame_refs[f]);
        end
      end
      MODE_GETREF: begin
        if (!frame_ok(a, f)) r.status = STAT_BAD_ADDR;
        else r.value = VALUE_W'(frame_refs[f]);
      end
      MODE_COUNT: r.value = free_frames;
      default: ;
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      bad_fields++;
    end
  endfunction

  // Predict on each input transfer, compare on each result transfer
  always @(posedge clk) begin
    frame_reply_t want;
    if (!rst_n) begin
      foreach (frame_refs[i]) begin
        frame_refs[i] = '0;
        frame_link[i] = '0;
      end
      head_frame    = '0;
      list_is_empty = 1'b1;
      free_frames   = '0;
      base_frame    = '0;
      replies_due.delete();
    end else begin
      if (cfg_we) base_frame = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with nothing expected: status %0d address %0h value %0d",
                 out_mon.status, out_mon.result_address, out_mon.value);
          bad_fields++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_mon.status);
          check_field("result_address", want.result_address, out_mon.result_address);
          check_field("value", want.value, out_mon.value);
          check_field("page_released", want.page_released, out_mon.page_released);
        end
      end
      if (in_mon.valid && in_mon.ready)
        replies_due.push_back(compute_frame_reply(in_mon.mode, in_mon.page_address));
    end
    pending <= replies_due.size();
  end

endmodule

### tb/refcounted_page_frame_allocator_core_tb.sv
// Stimulus and verdict for the page frame allocator; checking lives in
// rpfa_frame_checker.
module refcounted_page_frame_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpfa_pkg::*;

  localparam int NUM_PAGES    = 32768;
  localparam int COUNT_BITS   = 16;
  localparam int TOP_FRAME    = NUM_PAGES - 1;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASES       = 6;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int HOLD_CYCLES  = 400;

  // Mode code outside the defined set; the block answers all zeros
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rpfa_in_if  in_chan ();
  rpfa_out_if out_chan ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles;

  // Sender and receiver shaping
  bit steady;
  bit long_hold;
  int burst_left;
  int gap_left;
  int cur_base;
  int phase_base [PHASES];
  bit phase_init [PHASES];

  refcounted_page_frame_allocator_core #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rpfa_frame_checker #(
    .NUM_PAGES (NUM_PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) frame_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("refcounted_page_frame_allocator_core verification failed");
    $finish;
  end

  // Receiver: rotating stall mask, or a long hold on request
  initial begin
    logic [15:0] stall_mask;
    int          hold_left;
    out_chan.ready <= 1'b0;
    stall_mask = 16'hFFFF;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_chan.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else begin
        out_chan.ready <= steady ? 1'b1 : stall_mask[0];
        stall_mask = {stall_mask[0], stall_mask[15:1]};
        if ($urandom_range(0, 63) == 0) begin
          stall_mask = 16'($urandom) | 16'h0101;
          if ($urandom_range(0, 3) == 0) stall_mask = 16'hFFFF;
        end
        @(posedge clk);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] frame_addr(input int f);
    return {f[IDX_W-1:0], {PAGE_SHIFT{1'b0}}};
  endfunction

  // One input transfer; returns at the edge that took it
  task automatic send_op(input logic [MODE_W-1:0] m, input logic [ADDR_W-1:0] a);
    if (!steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      while (gap_left > 0) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        gap_left--;
      end
      burst_left--;
    end
    in_chan.valid        <= 1'b1;
    in_chan.mode         <= m;
    in_chan.page_address <= a;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_first_frame(input int f);
    wait_all_results();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(f);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_base = f;
  endtask

  // Mostly operations on frames near the top of the pool, where allocs land
  task automatic random_op();
    int                roll;
    int                f;
    int                span;
    logic [MODE_W-1:0] m;
    logic [ADDR_W-1:0] a;
    span = (TOP_FRAME - cur_base > 63) ? 63 : TOP_FRAME - cur_base;
    f    = TOP_FRAME - int'($urandom_range(0, span));
    a    = frame_addr(f);
    roll = $urandom_range(0, 99);
    if (roll < 28) m = MODE_ALLOC;
    else if (roll < 50) m = MODE_FREE;
    else if (roll < 64) m = MODE_INCREF;
    else if (roll < 74) m = MODE_DECREF;
    else if (roll < 84) m = MODE_GETREF;
    else if (roll < 94) m = MODE_COUNT;
    else m = MODE_UNUSED;
    // misaligned, below the managed range, or junk addresses
    roll = $urandom_range(0, 99);
    if (roll < 7) a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom_range(1, 4095));
    else if (roll < 12 && cur_base > 0) a = frame_addr($urandom_range(0, cur_base - 1));
    else if (roll < 16) a = ADDR_W'($urandom);
    send_op(m, a);
  endtask

  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    in_chan.valid        <= 1'b0;
    in_chan.mode         <= MODE_INIT;
    in_chan.page_address <= '0;
    steady     = 1'b1;
    long_hold  = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    cur_base   = 0;
    phase_base = '{TOP_FRAME - 7, TOP_FRAME - 67, 0, TOP_FRAME, 0, TOP_FRAME - 15};
    phase_base[4] = $urandom_range(32000, TOP_FRAME);
    phase_init = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list out of reset, underflow, unused mode, bad address
    send_op(MODE_COUNT, '0);
    send_op(MODE_ALLOC, '0);
    send_op(MODE_GETREF, frame_addr(0));
    send_op(MODE_FREE, frame_addr(5));
    send_op(MODE_DECREF, frame_addr(TOP_FRAME));
    send_op(MODE_UNUSED, '1);
    send_op(MODE_GETREF, '1);

    // Small pool: count lifecycle, decref to zero, duplicate push, then allocs
    set_first_frame(TOP_FRAME - 7);
    send_op(MODE_INIT, '1);
    send_op(MODE_GETREF, frame_addr(TOP_FRAME - 8));
    send_op(MODE_ALLOC, '0);
    send_op(MODE_INCREF, frame_addr(TOP_FRAME));
    send_op(MODE_DECREF, frame_addr(TOP_FRAME));
    send_op(MODE_FREE, frame_addr(TOP_FRAME));
    send_op(MODE_ALLOC, '0);
    send_op(MODE_DECREF, frame_addr(TOP_FRAME));
    send_op(MODE_COUNT, '0);
    send_op(MODE_INCREF, frame_addr(TOP_FRAME - 1));
    send_op(MODE_FREE, frame_addr(TOP_FRAME - 1));
    send_op(MODE_COUNT, '0);
    repeat (6) send_op(MODE_ALLOC, '0);

    // Single-frame pool: shared frame kept by a free, then an empty list
    set_first_frame(TOP_FRAME);
    send_op(MODE_INIT, '0);
    send_op(MODE_ALLOC, '0);
    repeat (3) send_op(MODE_INCREF, frame_addr(TOP_FRAME));
    send_op(MODE_GETREF, frame_addr(TOP_FRAME));
    send_op(MODE_FREE, frame_addr(TOP_FRAME));
    send_op(MODE_ALLOC, '0);

    // Random phases over several first-frame settings
    steady = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_first_frame(phase_base[ph]);
      if (phase_init[ph]) send_op(MODE_INIT, ADDR_W'($urandom));
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
        // receiver holds off while the sender keeps offering
        if (ph == 0 && i == 100) long_hold = 1'b1;
        if (ph == 1 && i == 150) wait_all_results();
        random_op();
      end
    end

    wait_all_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("refcounted_page_frame_allocator_core verification clean");
    else
      $display("refcounted_page_frame_allocator_core verification failed");
    $finish;
  end

endmodule
